>>> rtl/pdvl_pkg.sv
// Shared types and constants for the phase-distortion velocity LFO.
// No dependencies; used by every module of the block.
package pdvl_pkg;

  // Fixed field widths
  localparam int FREQ_W = 24;
  localparam int SR_W   = 18;
  localparam int CL_W   = 7;
  localparam int PCT_W  = 7;
  localparam int VEL_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Divisor is sample_rate * curve_length
  localparam int DIV_W = SR_W + CL_W;

  // Velocity constants
  localparam logic [VEL_W-1:0] VEL_MAX   = 7'd127;
  localparam logic [VEL_W-1:0] VEL_NEAR  = 7'd126;
  localparam logic [VEL_W-1:0] VEL_LOW   = 7'd50;
  localparam int               VEL_STEPS = 7;

  // Breakpoint percent saturates here
  localparam int PCT_MAX = 100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE  = 2'd0,
    CFG_CURVE_LENGTH = 2'd1,
    CFG_BP_PERCENT   = 2'd2,
    CFG_CLIP_MODE    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SR_W-1:0]  sample_rate;
    logic [CL_W-1:0]  curve_length;
    logic [PCT_W-1:0] bp_percent;
    logic             clip_mode;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic vel_step;
    logic inc_step;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/pdvl_ctrl.sv
// Sequencer for the LFO: accepts a tick, steps the two serial dividers,
// then retires the result. Depends on pdvl_pkg.
module pdvl_ctrl #(
  parameter int PHASE_BITS     = 24,
  parameter int FREQ_FRAC_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  pdvl_pkg::dp_status_t   status_i,
  output pdvl_pkg::ctrl_cmd_t    cmd_o
);

  // One quotient bit per dividend bit of freq << shift
  localparam int IncSteps = pdvl_pkg::FREQ_W + PHASE_BITS + 1 - FREQ_FRAC_BITS;
  localparam int CntW     = $clog2(IncSteps);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StVel  = 3'd2;
  localparam logic [2:0] StInc  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = StPrep;
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        cnt_d      = CntW'(pdvl_pkg::VEL_STEPS - 1);
        state_d    = StVel;
      end
      StVel: begin
        cmd_o.vel_step = 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CntW'(IncSteps - 1);
          state_d = StInc;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StInc: begin
        cmd_o.inc_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        // wait for room in the output register
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/pdvl_dp.sv
// Datapath of the LFO: phase/breakpoint state, velocity divider, increment
// divider, clip latch and output register. Depends on pdvl_pkg.
module pdvl_dp #(
  parameter int PHASE_BITS     = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pdvl_pkg::cfg_t                cfg_i,
  input  pdvl_pkg::ctrl_cmd_t           cmd_i,
  output pdvl_pkg::dp_status_t          status_o,
  input  logic [pdvl_pkg::FREQ_W-1:0]   frequency_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pdvl_pkg::VEL_W-1:0]    velocity_o,
  output logic                          wrapped_o
);

  localparam int NW    = PHASE_BITS + 1;        // Q1.PB values
  localparam int RW    = NW + 7;                // 127 * num
  localparam int SW    = NW + 6;                // den << 6
  localparam int CW    = NW + 5;                // clip compare
  localparam int DIVW  = pdvl_pkg::DIV_W;
  localparam int VW    = pdvl_pkg::VEL_W;
  localparam int NPct  = 2 ** pdvl_pkg::PCT_W;
  localparam logic [NW-1:0] One = NW'(1) << PHASE_BITS;

  // Tick state
  logic [PHASE_BITS-1:0] phase_q;
  logic [NW-1:0]         bp_q;
  logic                  clip_latched_q;

  // Velocity divider
  logic [NW-1:0] num_q, den_q;
  logic [RW-1:0] rem_q;
  logic [SW-1:0] dsh_q;
  logic [VW-1:0] vq_q;
  logic          sat_q;

  // Increment divider
  logic [pdvl_pkg::FREQ_W-1:0] freq_q;
  logic [DIVW-1:0]             dv_q;
  logic [DIVW-1:0]             ir_q;
  logic [PHASE_BITS-1:0]       iq_q;
  logic                        ovf_q;

  // Output register
  logic          out_valid_q;
  logic [VW-1:0] vel_q;
  logic          wrap_q;

  // Breakpoint reload table, floor(pct * 2^PB / 100), zero percent -> 1 LSB
  logic [NW-1:0] bp_rom [NPct];
  for (genvar g = 0; g < NPct; g++) begin : g_bp_rom
    localparam longint unsigned PctSat =
        (g > pdvl_pkg::PCT_MAX) ? pdvl_pkg::PCT_MAX : g;
    localparam longint unsigned BpVal =
        (g == 0) ? 1 : ((PctSat << PHASE_BITS) / pdvl_pkg::PCT_MAX);
    assign bp_rom[g] = NW'(BpVal);
  end

  // Rising or falling segment of the curve
  logic [NW-1:0] phase_ext, num_d, den_d;
  always_comb begin
    phase_ext = {1'b0, phase_q};
    if (phase_ext < bp_q) begin
      num_d = phase_ext;
      den_d = bp_q;
    end else begin
      num_d = One - phase_ext;
      den_d = One - bp_q;
    end
  end

  // 127 * num, saturation check, effective divisor
  logic [RW-1:0]            num127;
  logic [pdvl_pkg::SR_W-1:0] sr_eff;
  logic [pdvl_pkg::CL_W-1:0] cl_eff;
  assign num127 = {num_q, 7'b0} - RW'(num_q);
  assign sr_eff = (cfg_i.sample_rate == '0) ? pdvl_pkg::SR_W'(1) : cfg_i.sample_rate;
  assign cl_eff = (cfg_i.curve_length == '0) ? pdvl_pkg::CL_W'(1) : cfg_i.curve_length;

  // Velocity division step
  logic          vbit;
  logic [RW-1:0] vtrial;
  assign vtrial = RW'(dsh_q);
  assign vbit   = (rem_q >= vtrial);

  // Increment division step
  logic [DIVW:0] itrial;
  logic          ibit;
  assign itrial = {ir_q, freq_q[pdvl_pkg::FREQ_W-1]};
  assign ibit   = (itrial >= {1'b0, dv_q});

  // Clip threshold: 127*num >= 126.88*den, via quotient and remainder
  logic [CW-1:0] r25, d22;
  logic          clip_high;
  assign r25 = (CW'(rem_q[NW-1:0]) << 4) + (CW'(rem_q[NW-1:0]) << 3) + CW'(rem_q[NW-1:0]);
  assign d22 = (CW'(den_q) << 4) + (CW'(den_q) << 2) + (CW'(den_q) << 1);
  assign clip_high = sat_q || (vq_q == pdvl_pkg::VEL_MAX) ||
                     ((vq_q == pdvl_pkg::VEL_NEAR) && (r25 >= d22));

  // Final velocity and phase advance
  logic [VW-1:0] vel_d;
  logic [NW-1:0] sum;
  logic          wrap_d;
  always_comb begin
    if (cfg_i.clip_mode) begin
      vel_d = (clip_high || clip_latched_q) ? pdvl_pkg::VEL_MAX : pdvl_pkg::VEL_LOW;
    end else begin
      vel_d = sat_q ? pdvl_pkg::VEL_MAX : vq_q;
    end
    sum    = {1'b0, phase_q} + {1'b0, iq_q};
    wrap_d = ovf_q || sum[PHASE_BITS];
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      freq_q <= frequency_i;
      num_q  <= num_d;
      den_q  <= den_d;
      ir_q   <= '0;
      iq_q   <= '0;
      vq_q   <= '0;
    end
    if (cmd_i.prep) begin
      rem_q <= num127;
      sat_q <= (num127 >= {den_q, 7'b0});
      dsh_q <= {den_q, 6'b0};
      dv_q  <= DIVW'(sr_eff) * DIVW'(cl_eff);
    end
    if (cmd_i.vel_step) begin
      if (vbit) begin
        rem_q <= rem_q - vtrial;
      end
      dsh_q <= dsh_q >> 1;
      vq_q  <= {vq_q[VW-2:0], vbit};
    end
    if (cmd_i.inc_step) begin
      ir_q   <= ibit ? DIVW'(itrial - {1'b0, dv_q}) : DIVW'(itrial);
      iq_q   <= {iq_q[PHASE_BITS-2:0], ibit};
      freq_q <= {freq_q[pdvl_pkg::FREQ_W-2:0], 1'b0};
    end
    if (cmd_i.finish) begin
      vel_q  <= vel_d;
      wrap_q <= wrap_d;
    end
  end

  // Overflow of the increment quotient past the phase width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else if (cmd_i.load) begin
      ovf_q <= 1'b0;
    end else if (cmd_i.inc_step) begin
      ovf_q <= ovf_q | iq_q[PHASE_BITS-1];
    end
  end

  // Tick state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= '0;
      bp_q           <= NW'(1) << (PHASE_BITS - 1);
      clip_latched_q <= 1'b0;
    end else if (cmd_i.finish) begin
      phase_q <= sum[PHASE_BITS-1:0];
      if (wrap_d) begin
        bp_q <= bp_rom[cfg_i.bp_percent];
      end
      if (cfg_i.clip_mode && clip_high) begin
        clip_latched_q <= 1'b1;
      end
    end
  end

  // Output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign velocity_o        = vel_q;
  assign wrapped_o         = wrap_q;

endmodule

>>> rtl/phase_distortion_velocity_lfo_core.sv
// Phase-distortion velocity LFO: each input beat is one tick carrying a frequency and
// yields one velocity beat. A new tick is accepted only once the previous one has
// retired; the pace is set by the bit-serial divider that forms the phase increment,
// one quotient bit per cycle, after a bit-serial velocity divide. A waiting result
// sits in an output register; a stalled output longer than the item delays retiring
// the next tick. Configuration writes are to be made only while idle; the block
// itself does not enforce this. Depends on pdvl_pkg, pdvl_ctrl and pdvl_dp.
module phase_distortion_velocity_lfo_core #(
  parameter int PHASE_BITS     = 24,
  parameter int FREQ_FRAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [pdvl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pdvl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // tick input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pdvl_pkg::FREQ_W-1:0]       frequency_i,
  // velocity output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pdvl_pkg::VEL_W-1:0]        velocity_o,
  output logic                              wrapped_o
);

  pdvl_pkg::cfg_t       cfg_q;
  pdvl_pkg::ctrl_cmd_t  cmd;
  pdvl_pkg::dp_status_t status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate  <= pdvl_pkg::SR_W'(48000);
      cfg_q.curve_length <= pdvl_pkg::CL_W'(1);
      cfg_q.bp_percent   <= pdvl_pkg::PCT_W'(50);
      cfg_q.clip_mode    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (pdvl_pkg::cfg_idx_e'(cfg_index_i))
        pdvl_pkg::CFG_SAMPLE_RATE:  cfg_q.sample_rate  <= cfg_wdata_i[pdvl_pkg::SR_W-1:0];
        pdvl_pkg::CFG_CURVE_LENGTH: cfg_q.curve_length <= cfg_wdata_i[pdvl_pkg::CL_W-1:0];
        pdvl_pkg::CFG_BP_PERCENT:   cfg_q.bp_percent   <= cfg_wdata_i[pdvl_pkg::PCT_W-1:0];
        pdvl_pkg::CFG_CLIP_MODE:    cfg_q.clip_mode    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  pdvl_ctrl #(
    .PHASE_BITS     (PHASE_BITS),
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pdvl_dp #(
    .PHASE_BITS     (PHASE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .frequency_i (frequency_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .velocity_o  (velocity_o),
    .wrapped_o   (wrapped_o)
  );

endmodule

>>> sim/phase_distortion_velocity_lfo_core_tb.sv
// Self-checking testbench for phase_distortion_velocity_lfo_core: a directed table, then
// random ticks over many register settings. Every result is checked against a local LFO model
// or a directed row's typed result. Depends on pdvl_pkg and the RTL of the block; nothing else.
module phase_distortion_velocity_lfo_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BITS     = 24;
  localparam int FREQ_FRAC_BITS = 12;
  localparam longint unsigned PHASE_ONE = 64'd1 << PHASE_BITS;

  localparam int N_PHASES         = 12;
  localparam int ITEMS_PER_PHASE  = 160;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 100;
  localparam int CYCLE_LIMIT      = 1_000_000;

  // One result beat
  typedef struct packed {
    logic [pdvl_pkg::VEL_W-1:0] velocity;
    logic                       wrapped;
  } vel_beat_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  // Directed row: either a register write or a tick, with an optional hand-written result
  typedef struct packed {
    row_kind_e                       kind;
    pdvl_pkg::cfg_idx_e              idx;
    logic [pdvl_pkg::CFG_DATA_W-1:0] data;
    logic [pdvl_pkg::FREQ_W-1:0]     freq;
    logic                            typed;
    vel_beat_t                       want;
  } stim_row_t;

  localparam vel_beat_t NO_CHECK = '{7'd0, 1'b0};
  localparam int N_ROWS = 37;

  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // state after reset: phase zero reads as zero
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000000, 1'b1, '{7'd0, 1'b0}},
    // smallest divisor, zero percent, clip on
    '{ROW_CFG, pdvl_pkg::CFG_SAMPLE_RATE, 18'd1, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_CURVE_LENGTH, 18'd1, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_BP_PERCENT, 18'd0, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_CLIP_MODE, 18'd1, 24'h000000, 1'b0, NO_CHECK},
    // increment of exactly one turn: wraps, breakpoint reloads as one LSB
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000800, 1'b1, '{pdvl_pkg::VEL_LOW, 1'b1}},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000001, 1'b1, '{pdvl_pkg::VEL_LOW, 1'b0}},
    // just past a one-LSB breakpoint the falling curve is near 1.0: latch sets
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000000, 1'b1, '{pdvl_pkg::VEL_MAX, 1'b0}},
    '{ROW_CFG, pdvl_pkg::CFG_CLIP_MODE, 18'd0, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000000, 1'b1, '{pdvl_pkg::VEL_NEAR, 1'b0}},
    // clip back on: latch still holds
    '{ROW_CFG, pdvl_pkg::CFG_CLIP_MODE, 18'd1, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000100, 1'b1, '{pdvl_pkg::VEL_MAX, 1'b0}},
    // zero rate and zero length count as one; multi-turn increment
    '{ROW_CFG, pdvl_pkg::CFG_CLIP_MODE, 18'd0, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_CURVE_LENGTH, 18'd0, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'hFFFFFF, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000001, 1'b0, NO_CHECK},
    // percent above 100 saturates: breakpoint of exactly 1.0
    '{ROW_CFG, pdvl_pkg::CFG_BP_PERCENT, 18'd127, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000800, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h0007FF, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000555, 1'b0, NO_CHECK},
    // largest sample rate, curve length 64
    '{ROW_CFG, pdvl_pkg::CFG_SAMPLE_RATE, 18'd262143, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_CURVE_LENGTH, 18'd64, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_BP_PERCENT, 18'd100, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'hFFFFFF, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h800000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h7FFFFF, 1'b0, NO_CHECK},
    // back to audio-like settings
    '{ROW_CFG, pdvl_pkg::CFG_SAMPLE_RATE, 18'd48000, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_CURVE_LENGTH, 18'd1, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_BP_PERCENT, 18'd50, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'hAAAAAA, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h555555, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h000FFF, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'hFFFFFF, 1'b0, NO_CHECK},
    '{ROW_CFG, pdvl_pkg::CFG_BP_PERCENT, 18'd1, 24'h000000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'hC00000, 1'b0, NO_CHECK},
    '{ROW_TICK, pdvl_pkg::CFG_SAMPLE_RATE, 18'd0, 24'h3FFFFF, 1'b0, NO_CHECK}
  };

  // DUT ports
  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [pdvl_pkg::CFG_IDX_W-1:0]  cfg_index_i = pdvl_pkg::CFG_SAMPLE_RATE;
  logic [pdvl_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [pdvl_pkg::FREQ_W-1:0]     frequency_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [pdvl_pkg::VEL_W-1:0]      velocity_o;
  logic                            wrapped_o;

  phase_distortion_velocity_lfo_core #(
    .PHASE_BITS     (PHASE_BITS),
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .frequency_i (frequency_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .velocity_o  (velocity_o),
    .wrapped_o   (wrapped_o)
  );

  // LFO model state and register copy, at reset values
  logic [PHASE_BITS-1:0] lfo_phase   = '0;
  logic [PHASE_BITS:0]   lfo_bp      = (PHASE_BITS+1)'(PHASE_ONE >> 1);
  bit                    clip_latch  = 1'b0;
  pdvl_pkg::cfg_t        lfo_cfg     = '{18'd48000, 7'd1, 7'd50, 1'b0};

  vel_beat_t   pending_vel_q [$];
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  bit          src_idle_en    = 1'b1;
  bit          sink_idle_en   = 1'b1;
  bit          long_hold_req  = 1'b0;
  bit          long_hold_done = 1'b0;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Velocity of the current phase, then phase advance and breakpoint reload on wrap
  function automatic vel_beat_t lfo_advance(input logic [pdvl_pkg::FREQ_W-1:0] freq);
    longint unsigned num, den, vel, divisor, step, sum, pct;
    bit              high;
    vel_beat_t       beat;
    if (64'(lfo_phase) < 64'(lfo_bp)) begin
      num = 64'(lfo_phase);
      den = 64'(lfo_bp);
    end else begin
      num = PHASE_ONE - 64'(lfo_phase);
      den = PHASE_ONE - 64'(lfo_bp);
    end
    if (den == 0) begin
      vel = 64'(pdvl_pkg::VEL_MAX);
    end else begin
      vel = (127 * num) / den;
      if (vel > 64'(pdvl_pkg::VEL_MAX)) vel = 64'(pdvl_pkg::VEL_MAX);
    end
    // clip: 127*value >= 126.88, exact in integers; latch is sticky
    if (lfo_cfg.clip_mode) begin
      high = (den == 0) || (12700 * num >= 12688 * den);
      if (high || clip_latch) begin
        vel        = 64'(pdvl_pkg::VEL_MAX);
        clip_latch = 1'b1;
      end else begin
        vel = 64'(pdvl_pkg::VEL_LOW);
      end
    end
    divisor = (lfo_cfg.sample_rate != 0 ? 64'(lfo_cfg.sample_rate) : 64'd1)
            * (lfo_cfg.curve_length != 0 ? 64'(lfo_cfg.curve_length) : 64'd1);
    step = (64'(freq) << (PHASE_BITS + 1 - FREQ_FRAC_BITS)) / divisor;
    sum  = 64'(lfo_phase) + step;
    beat.wrapped = (sum >= PHASE_ONE);
    if (beat.wrapped) begin
      pct = (64'(lfo_cfg.bp_percent) > 64'(pdvl_pkg::PCT_MAX)) ?
            64'(pdvl_pkg::PCT_MAX) : 64'(lfo_cfg.bp_percent);
      lfo_bp = (pct == 0) ? (PHASE_BITS+1)'(1) : (PHASE_BITS+1)'((pct * PHASE_ONE) / 100);
    end
    lfo_phase     = sum[PHASE_BITS-1:0];
    beat.velocity = vel[pdvl_pkg::VEL_W-1:0];
    return beat;
  endfunction

  // Offer one tick, hold it until taken, then maybe leave a gap
  task automatic send_tick(input logic [pdvl_pkg::FREQ_W-1:0] f, input bit typed,
                           input vel_beat_t typed_beat);
    vel_beat_t beat;
    in_valid_i  <= 1'b1;
    frequency_i <= f;
    do @(posedge clk_i); while (in_stall_o);
    beat = lfo_advance(f);
    if (typed) beat = typed_beat;
    pending_vel_q.push_back(beat);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Register write, only once the block has drained
  task automatic write_reg(input pdvl_pkg::cfg_idx_e idx,
                           input logic [pdvl_pkg::CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    while (pending_vel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pdvl_pkg::CFG_SAMPLE_RATE:  lfo_cfg.sample_rate  = val[pdvl_pkg::SR_W-1:0];
      pdvl_pkg::CFG_CURVE_LENGTH: lfo_cfg.curve_length = val[pdvl_pkg::CL_W-1:0];
      pdvl_pkg::CFG_BP_PERCENT:   lfo_cfg.bp_percent   = val[pdvl_pkg::PCT_W-1:0];
      pdvl_pkg::CFG_CLIP_MODE:    lfo_cfg.clip_mode    = val[0];
      default: ;
    endcase
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : vel_check
    vel_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_vel_q.size() == 0) begin
        $error("unexpected velocity beat: velocity %0d wrapped %0d", velocity_o, wrapped_o);
        mismatch_cnt++;
      end else begin
        want = pending_vel_q.pop_front();
        if (velocity_o !== want.velocity) begin
          $error("velocity: expected %0d, got %0d", want.velocity, velocity_o);
          mismatch_cnt++;
        end
        if (wrapped_o !== want.wrapped) begin
          $error("wrapped: expected %0d, got %0d", want.wrapped, wrapped_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("phase_distortion_velocity_lfo_core: mismatch");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [pdvl_pkg::FREQ_W-1:0]     freq_val;
    logic [pdvl_pkg::CFG_DATA_W-1:0] sr_val, cl_val, pct_val;
    freq_val = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_tick(DIRECTED[r].freq, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      src_idle_en  = (p % 3 != 1) && (p != 3) && (p < N_PHASES - 2);
      sink_idle_en = (p % 3 != 2) && (p < N_PHASES - 2);

      case ($urandom_range(0, 4))
        0:       sr_val = 18'd1;
        1:       sr_val = 18'd262143;
        2:       sr_val = 18'd48000;
        3:       sr_val = 18'd0;
        default: sr_val = pdvl_pkg::CFG_DATA_W'($urandom_range(0, 262143));
      endcase
      case ($urandom_range(0, 4))
        0:       cl_val = 18'd1;
        1:       cl_val = 18'd64;
        2:       cl_val = 18'd127;
        3:       cl_val = 18'd0;
        default: cl_val = pdvl_pkg::CFG_DATA_W'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 3))
        0:       pct_val = 18'd0;
        1:       pct_val = 18'd100;
        default: pct_val = pdvl_pkg::CFG_DATA_W'($urandom_range(0, 127));
      endcase
      write_reg(pdvl_pkg::CFG_SAMPLE_RATE, sr_val);
      write_reg(pdvl_pkg::CFG_CURVE_LENGTH, cl_val);
      write_reg(pdvl_pkg::CFG_BP_PERCENT, pct_val);
      write_reg(pdvl_pkg::CFG_CLIP_MODE, pdvl_pkg::CFG_DATA_W'($urandom_range(0, 1)));

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // receiver holds off while ticks keep coming: block fills and stalls
        if (p == 3 && i == 20) long_hold_req = 1'b1;
        // sender waits for the pipeline to empty
        if (p == 6 && i == 80) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_vel_q.size() != 0);
        end
        case ($urandom_range(0, 7))
          0, 1, 2: freq_val = pdvl_pkg::FREQ_W'($urandom());
          3:       freq_val = pdvl_pkg::FREQ_W'($urandom_range(0, 255));
          4:       freq_val = pdvl_pkg::FREQ_W'($urandom_range(0, 65535));
          5:       ;  // held frequency
          6:       freq_val = freq_val + pdvl_pkg::FREQ_W'($urandom_range(0, 4095));
          default: freq_val = $urandom_range(0, 1) ? '1 : '0;
        endcase
        send_tick(freq_val, 1'b0, NO_CHECK);
      end
    end

    // drain and let the tail run out
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_vel_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("phase_distortion_velocity_lfo_core: match");
    end else begin
      $display("phase_distortion_velocity_lfo_core: mismatch");
    end
    $finish;
  end

endmodule
